[src/dot_bracket_pair_parser_defines.svh]
// Assertion macros shared by the dot-bracket pair parser RTL.
// The macros expect i_clk and i_rst_n in the module that uses them; define ASSERT_OFF to drop them.
`ifndef DOT_BRACKET_PAIR_PARSER_DEFINES_SVH
`define DOT_BRACKET_PAIR_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks that a condition holds on every clock edge outside reset.
`define DBP_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dot_bracket_pair_parser: assertion failed");
// Checks that the consequent holds on the clock edge after the antecedent.
`define DBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dot_bracket_pair_parser: assertion failed");
`else
`define DBP_ASSERT(lbl, cond)
`define DBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/dbp_pkg.sv]
// Shared types and constants of the dot-bracket pair parser.
// Used by every module of the block; depends on nothing.
package dbp_pkg;

    localparam int MAX_LENGTH  = 1024;
    localparam int STACK_DEPTH = 512;

    localparam int POS_W    = 10;
    localparam int BASE_W   = 2;
    localparam int SYM_W    = 2;
    localparam int ENTRY_W  = POS_W + BASE_W;
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);

    localparam int MIN_LOOP_W = 4;
    localparam int PAIRS_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [POS_W-1:0] COUNTER_MAX = {POS_W{1'b1}};

    localparam logic [SYM_W-1:0] SYM_OPEN  = 2'd0;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED  = 2'd1;

    localparam logic [MIN_LOOP_W-1:0] MIN_LOOP_RST = 4'd3;
    localparam logic [PAIRS_W-1:0]    ALLOWED_RST  = 16'd23112;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNMATCHED = 3'd1,
        ST_LOOP      = 3'd2,
        ST_PAIR      = 3'd3,
        ST_UNCLOSED  = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_DOT   = 2'd2
    } t_op;

    // One classified position on its way from the front end to the stack engine.
    typedef struct packed {
        t_op               op;
        logic [BASE_W-1:0] base;
        logic              last;
        logic [POS_W-1:0]  idx;
        logic              too_long;
    } t_item;

    typedef struct packed {
        logic [MIN_LOOP_W-1:0] min_loop;
        logic [PAIRS_W-1:0]    allowed_pairs;
    } t_cfg;

endpackage

[src/dbp_front.sv]
// Front end of the dot-bracket pair parser: position counter and symbol classification.
// Depends on dbp_pkg.
module dbp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_symbol,
    input  logic [1:0]    i_base,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output dbp_pkg::t_item o_item
);
    import dbp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             accept;
    t_op              op;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_q_wr  = accept;

    always_comb begin
        unique case (i_symbol)
            SYM_OPEN:  op = OP_OPEN;
            SYM_CLOSE: op = OP_CLOSE;
            default:   op = OP_DOT;
        endcase
    end

    always_comb begin
        o_item.op       = op;
        o_item.base     = i_base;
        o_item.last     = i_last;
        o_item.idx      = r_pos;
        o_item.too_long = (32'(r_pos) >= MAX_LENGTH) || ((r_pos == COUNTER_MAX) && !i_last);
    end

    // The counter saturates at its maximum and restarts after the last position.
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_last) begin
                n_pos = '0;
            end else if (r_pos != COUNTER_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

[src/dbp_queue.sv]
// Short queue of classified items between the front end and the stack engine.
// Depends on dbp_pkg.
module dbp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dbp_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output dbp_pkg::t_item o_item
);
    import dbp_pkg::*;

    t_item                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp;
    logic [QUEUE_AW-1:0]  r_rp;
    logic [QUEUE_AW:0]    r_cnt;
    logic                 wr_en;
    logic                 rd_en;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_slot[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QUEUE_AW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
        end
    end

endmodule

[src/dbp_back.sv]
// Stack engine of the dot-bracket pair parser: open-bracket stack, pair checks, result register.
// Depends on dbp_pkg and dot_bracket_pair_parser_defines.svh.
module dbp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dbp_pkg::t_cfg        i_cfg,
    input  logic                 i_q_valid,
    input  dbp_pkg::t_item       i_item,
    output logic                 o_q_rd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [dbp_pkg::POS_W-1:0] o_position,
    output logic [dbp_pkg::POS_W-1:0] o_partner,
    output logic                 o_paired,
    output logic [2:0]           o_status,
    output logic                 o_done_res
);
    import dbp_pkg::*;
    `include "dot_bracket_pair_parser_defines.svh"

    localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);

    // Entries below the top live in memory; the top is held in a register and the
    // entry under it is read ahead into a register, so that a pop does not wait for a memory read.
    logic [ENTRY_W-1:0]  r_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]  r_rd_data;
    logic [ENTRY_W-1:0]  r_byp_data;
    logic                r_byp;
    logic [ENTRY_W-1:0]  r_top;
    logic [ENTRY_W-1:0]  n_top;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    t_status             r_err;
    t_status             n_err;
    t_status             res_status;

    logic                r_valid;
    logic [POS_W-1:0]    r_position;
    logic [POS_W-1:0]    r_partner;
    logic                r_paired;
    t_status             r_status;
    logic                r_done;

    logic                pop;
    logic                we;
    logic [STACK_AW-1:0] wa;
    logic [STACK_AW-1:0] ra;
    logic [ENTRY_W-1:0]  second;
    logic [POS_W-1:0]    top_pos;
    logic [BASE_W-1:0]   top_base;
    logic [POS_W-1:0]    loop_dist;
    logic [POS_W-1:0]    partner;
    logic                paired;

    assign pop       = i_q_valid && (!r_valid || i_ready);
    assign o_q_rd    = pop;
    assign second    = r_byp ? r_byp_data : r_rd_data;
    assign top_pos   = r_top[ENTRY_W-1:BASE_W];
    assign top_base  = r_top[BASE_W-1:0];
    assign loop_dist = i_item.idx - top_pos;
    assign wa        = STACK_AW'(r_count - CNT_W'(1));
    assign ra        = STACK_AW'(n_count - CNT_W'(2));

    always_comb begin
        n_count    = r_count;
        n_err      = r_err;
        n_top      = r_top;
        partner    = '0;
        paired     = 1'b0;
        we         = 1'b0;
        res_status = r_err;
        if (pop) begin
            if (r_err == ST_OK) begin
                if (i_item.too_long) begin
                    n_err = ST_TOO_LONG;
                end else begin
                    unique case (i_item.op)
                        OP_OPEN: begin
                            if (r_count >= STACK_FULL) begin
                                n_err = ST_TOO_LONG;
                            end else begin
                                we      = (r_count != '0);
                                n_top   = {i_item.idx, i_item.base};
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_CLOSE: begin
                            if (r_count == '0) begin
                                n_err = ST_UNMATCHED;
                            end else if ((top_pos > i_item.idx)
                                         || (loop_dist <= POS_W'(i_cfg.min_loop))) begin
                                n_err = ST_LOOP;
                            end else if (!i_cfg.allowed_pairs[{top_base, i_item.base}]) begin
                                n_err = ST_PAIR;
                            end else begin
                                n_top   = second;
                                n_count = r_count - CNT_W'(1);
                                partner = top_pos;
                                paired  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (i_item.last && (n_err == ST_OK) && (n_count != '0)) begin
                    n_err = ST_UNCLOSED;
                end
            end
            res_status = n_err;
            if (i_item.last) begin
                n_count = '0;
                n_err   = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= r_top;
        end
        r_rd_data  <= r_mem[ra];
        r_byp_data <= r_top;
        r_top      <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_position <= i_item.idx;
            r_partner  <= partner;
            r_paired   <= paired;
            r_status   <= res_status;
            r_done     <= i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= ST_OK;
            r_byp   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            r_byp   <= we && (wa == ra);
            if (pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_position = r_position;
    assign o_partner  = r_partner;
    assign o_paired   = r_paired;
    assign o_status   = r_status;
    assign o_done_res = r_done;

    // A pair made on the last position may still leave opens behind, which shows as unclosed.
    `DBP_ASSERT(a_count_bound, r_count <= STACK_FULL)
    `DBP_ASSERT_NEXT(a_last_clears, pop && i_item.last, (r_count == '0) && (r_err == ST_OK))
    `DBP_ASSERT(a_paired_ok, !(r_valid && r_paired) || (r_status == ST_OK) || (r_done && (r_status == ST_UNCLOSED)))
    `DBP_ASSERT_NEXT(a_error_sticky, pop && !i_item.last && (r_err != ST_OK),
                     (r_err == $past(r_err)) && (r_count == $past(r_count)))

endmodule

[src/dot_bracket_pair_parser.sv]
// Dot-bracket pair parser: takes one position of an RNA secondary structure per transaction
// (symbol, nucleotide, last flag) and returns one result transaction for it with the position
// index, the partner index of a closing bracket, and the kept error status. The block sustains
// one transaction per clock cycle in both directions while the receiver is ready; an input
// is registered in the queue, and the stack engine performs its push or pop with the checks
// and registers the result. The stack holds no reset state, so there is no clearing pass
// after reset. Configuration registers are min_loop (index 0, data bits 3:0) and allowed_pairs
// (index 1, data bits 15:0); they must be written only while the block is idle, which the
// block itself does not enforce. Depends on dbp_pkg, dbp_front, dbp_queue and dbp_back.
module dot_bracket_pair_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel: one structure position per transaction.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_symbol,
    input  logic [1:0]  i_base,
    input  logic        i_last,
    // Output channel: one result per input transaction.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [dbp_pkg::POS_W-1:0] o_position,
    output logic [dbp_pkg::POS_W-1:0] o_partner,
    output logic        o_paired,
    output logic [2:0]  o_status,
    output logic        o_done_res
);
    import dbp_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  q_full;
    logic  q_wr;
    logic  q_valid;
    logic  q_rd;

    // The configuration port never stalls. Writes to unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_loop      <= MIN_LOOP_RST;
            r_cfg.allowed_pairs <= ALLOWED_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_LOOP: r_cfg.min_loop      <= i_cfg_data[MIN_LOOP_W-1:0];
                CFG_ALLOWED:  r_cfg.allowed_pairs <= i_cfg_data[PAIRS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end numbers each position and classifies its symbol; it stalls only
    // when the queue is full.
    dbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_symbol (i_symbol),
        .i_base   (i_base),
        .i_last   (i_last),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_item   (front_item)
    );

    // The queue lets the front end keep taking transactions while the output side stalls.
    dbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // The stack engine performs the push or pop, runs the loop and pair checks, keeps the
    // first error of the structure, and drives the output register.
    dbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_q_rd     (q_rd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_position (o_position),
        .o_partner  (o_partner),
        .o_paired   (o_paired),
        .o_status   (o_status),
        .o_done_res (o_done_res)
    );

endmodule

[sim/tb_dot_bracket_pair_parser.sv]
// Self-checking testbench for the dot-bracket pair parser.
// Depends on dbp_pkg and the dot_bracket_pair_parser RTL; needs no other files.
module tb_dot_bracket_pair_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import dbp_pkg::*;

    // The package names only the open and close symbols. A dot is symbol 2, and
    // symbol 3 carries no meaning, so the block must treat it as a dot.
    localparam logic [SYM_W-1:0] SYM_DOT   = 2'd2;
    localparam logic [SYM_W-1:0] SYM_SPARE = 2'd3;

    localparam logic [BASE_W-1:0] BASE_A = 2'd0;
    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;
    localparam logic [BASE_W-1:0] BASE_U = 2'd3;

    // Register indexes 2 and 3 decode to nothing; writes to them must be no-ops.
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD3 = 2'd3;

    // The longest correct silence is the deliberate receiver hold-off. The limit
    // leaves a wide margin over that.
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_TRIGGER = 300;
    // The final wait lets a stray trailing result still be seen.
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic {CMD_ITEM, CMD_CFG} t_cmd_kind;
    typedef enum logic [1:0] {GEN_CLEAN, GEN_BROKEN, GEN_NOISE} t_gen_mode;

    // One queued piece of stimulus: either a structure position or a register write.
    typedef struct {
        t_cmd_kind              kind;
        logic [SYM_W-1:0]       symbol;
        logic [BASE_W-1:0]      base;
        logic                   last;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
    } t_cmd;

    // What the block should return for one position.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] partner;
        logic             paired;
        t_status          status;
        logic             done;
    } t_site_result;

    // DUT ports. Every input starts at a known value.
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic                   o_ready;
    logic [SYM_W-1:0]       i_symbol    = '0;
    logic [BASE_W-1:0]      i_base      = '0;
    logic                   i_last      = 1'b0;
    logic                   o_valid;
    logic                   i_ready     = 1'b0;
    logic [POS_W-1:0]       o_position;
    logic [POS_W-1:0]       o_partner;
    logic                   o_paired;
    logic [2:0]             o_status;
    logic                   o_done_res;

    dot_bracket_pair_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_symbol    (i_symbol),
        .i_base      (i_base),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_position  (o_position),
        .o_partner   (o_partner),
        .o_paired    (o_paired),
        .o_status    (o_status),
        .o_done_res  (o_done_res)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Stimulus waiting to be driven, and results waiting to be seen.
    t_cmd         stim_q[$];
    t_site_result awaited_sites[$];

    // Handshake flags captured at the rising edge and read by the drivers at the
    // following falling edge.
    bit in_fire  = 1'b0;
    bit cfg_fire = 1'b0;
    int inputs_taken = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    // ------------------------------------------------------------------
    // Predictor: a private copy of the parser's stack, counters and registers.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]      opener_pos  [STACK_DEPTH];
    logic [BASE_W-1:0]     opener_base [STACK_DEPTH];
    int                    open_depth  = 0;
    logic [POS_W-1:0]      site_count  = '0;
    t_status               held_status = ST_OK;
    logic [MIN_LOOP_W-1:0] loop_limit  = MIN_LOOP_RST;
    logic [PAIRS_W-1:0]    pair_mask   = ALLOWED_RST;

    // Works out the result of one accepted position and advances the state.
    function automatic t_site_result predict_site(logic [SYM_W-1:0] sym,
                                                  logic [BASE_W-1:0] base, logic last);
        t_site_result      r;
        logic [POS_W-1:0]  top_pos;
        logic [BASE_W-1:0] top_base;
        r          = '0;
        r.position = site_count;
        r.done     = last;
        // Once an error is held, the rest of the structure is ignored up to its last
        // position: nothing is pushed, popped or checked.
        if (held_status == ST_OK) begin
            // A full counter that is not on the last position is a too-long fault.
            if (int'(site_count) >= MAX_LENGTH || (site_count == COUNTER_MAX && !last)) begin
                held_status = ST_TOO_LONG;
            end else if (sym == SYM_OPEN) begin
                // An open with the stack already full is also reported as too long.
                if (open_depth >= STACK_DEPTH) begin
                    held_status = ST_TOO_LONG;
                end else begin
                    opener_pos[open_depth]  = site_count;
                    opener_base[open_depth] = base;
                    open_depth++;
                end
            end else if (sym == SYM_CLOSE) begin
                if (open_depth == 0) begin
                    held_status = ST_UNMATCHED;
                end else begin
                    top_pos  = opener_pos[open_depth-1];
                    top_base = opener_base[open_depth-1];
                    // The loop check comes before the nucleotide check.
                    if (top_pos > site_count ||
                        int'(site_count) - int'(top_pos) <= int'(loop_limit)) begin
                        held_status = ST_LOOP;
                    end else if (!pair_mask[{top_base, base}]) begin
                        held_status = ST_PAIR;
                    end else begin
                        open_depth--;
                        r.partner = top_pos;
                        r.paired  = 1'b1;
                    end
                end
            end
            // Symbols 2 and 3 both fall through here as unpaired dots.
            if (last && held_status == ST_OK && open_depth != 0) begin
                held_status = ST_UNCLOSED;
            end
        end
        r.status = held_status;
        // The last position clears everything; otherwise the counter saturates.
        if (last) begin
            open_depth  = 0;
            site_count  = '0;
            held_status = ST_OK;
        end else if (site_count != COUNTER_MAX) begin
            site_count++;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation. The generator keeps its own view of the registers so
    // that clean structures only use pairs the block will accept at that point.
    // ------------------------------------------------------------------
    logic [MIN_LOOP_W-1:0] gen_loop = MIN_LOOP_RST;
    logic [PAIRS_W-1:0]    gen_mask = ALLOWED_RST;

    function automatic void queue_item(logic [SYM_W-1:0] sym, logic [BASE_W-1:0] base,
                                       logic last);
        t_cmd c;
        c          = '{kind: CMD_ITEM, default: '0};
        c.kind     = CMD_ITEM;
        c.symbol   = sym;
        c.base     = base;
        c.last     = last;
        stim_q.push_back(c);
    endfunction

    // The min_loop register only uses the low bits; the upper data bits get
    // random values so that each data bit is exercised.
    function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_cmd c;
        c = '{kind: CMD_CFG, default: '0};
        if (idx == CFG_MIN_LOOP) begin
            data[CFG_DATA_W-1:MIN_LOOP_W] = (CFG_DATA_W - MIN_LOOP_W)'($urandom());
            gen_loop = data[MIN_LOOP_W-1:0];
        end else if (idx == CFG_ALLOWED) begin
            gen_mask = data;
        end
        c.kind     = CMD_CFG;
        c.reg_idx  = idx;
        c.reg_data = data;
        stim_q.push_back(c);
    endfunction

    // Queues one structure of len positions. Clean structures open and close
    // brackets with legal pairs and enough loop distance; broken ones have one
    // position replaced by random content; noise is random throughout.
    function automatic void queue_structure(int len, t_gen_mode mode, bit closes_structure);
        int                open_at[$];
        logic [BASE_W-1:0] open_nt[$];
        logic [BASE_W-1:0] openers[$];
        logic [BASE_W-1:0] partners[$];
        logic [SYM_W-1:0]  sym;
        logic [BASE_W-1:0] base;
        int                flip;
        int                roll;
        bit                can_close;
        bit                wind_down;
        flip = (mode == GEN_BROKEN) ? int'($urandom_range(0, len - 1)) : -1;
        for (int b = 0; b < 4; b++) begin
            if (gen_mask[b*4 +: 4] != 0) openers.push_back(2'(b));
        end
        for (int p = 0; p < len; p++) begin
            partners = {};
            if (open_at.size() != 0) begin
                for (int b = 0; b < 4; b++) begin
                    if (gen_mask[{open_nt[$], 2'(b)}]) partners.push_back(2'(b));
                end
            end
            can_close = open_at.size() != 0 && partners.size() != 0 &&
                        (p - open_at[$]) > int'(gen_loop);
            // Near the end, stop opening and close whatever can be closed.
            wind_down = (len - p) <= open_at.size() + 1;
            roll = $urandom_range(0, 99);
            sym  = SYM_DOT;
            base = 2'($urandom_range(0, 3));
            if (mode == GEN_NOISE) begin
                sym = 2'($urandom_range(0, 3));
            end else if (wind_down) begin
                if (can_close) sym = SYM_CLOSE;
            end else if (roll < 35 && openers.size() != 0 && open_at.size() < STACK_DEPTH &&
                         (len - p) > open_at.size() + int'(gen_loop) + 2) begin
                sym = SYM_OPEN;
            end else if (roll < 70 && can_close) begin
                sym = SYM_CLOSE;
            end else if (roll >= 95) begin
                sym = SYM_SPARE;
            end
            if (mode != GEN_NOISE && sym == SYM_OPEN) begin
                base = openers[$urandom_range(0, openers.size() - 1)];
            end else if (mode != GEN_NOISE && sym == SYM_CLOSE) begin
                base = partners[$urandom_range(0, partners.size() - 1)];
            end
            if (p == flip) begin
                sym  = 2'($urandom_range(0, 3));
                base = 2'($urandom_range(0, 3));
            end
            if (sym == SYM_OPEN) begin
                open_at.push_back(p);
                open_nt.push_back(base);
            end else if (sym == SYM_CLOSE && open_at.size() != 0) begin
                void'(open_at.pop_back());
                void'(open_nt.pop_back());
            end
            queue_item(sym, base, closes_structure && p == len - 1);
        end
    endfunction

    // Mostly clean structures of short random length, with some broken ones and noise.
    function automatic void queue_random_phase(int target);
        int        start;
        int        roll;
        t_gen_mode mode;
        start = stim_q.size();
        while (stim_q.size() - start < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      mode = GEN_CLEAN;
            else if (roll < 85) mode = GEN_BROKEN;
            else                mode = GEN_NOISE;
            queue_structure($urandom_range(1, 40), mode, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued transactions at the falling edge, in bursts of random
    // length separated by random gaps. A register write waits until every
    // expected result has come back, so the block is idle when it is written.
    // ------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 1;

    always @(negedge i_clk) begin
        t_cmd c;
        logic next_valid;
        logic next_cfg_valid;
        next_valid     = i_valid && !in_fire;
        next_cfg_valid = i_cfg_valid && !cfg_fire;
        if (!i_rst_n) begin
            next_valid     = 1'b0;
            next_cfg_valid = 1'b0;
        end else if (!next_valid && !next_cfg_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (stim_q.size() != 0) begin
                c = stim_q[0];
                if (c.kind == CMD_ITEM) begin
                    void'(stim_q.pop_front());
                    next_valid = 1'b1;
                    i_symbol  <= c.symbol;
                    i_base    <= c.base;
                    i_last    <= c.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else if (awaited_sites.size() == 0) begin
                    void'(stim_q.pop_front());
                    next_cfg_valid = 1'b1;
                    i_cfg_index   <= c.reg_idx;
                    i_cfg_data    <= c.reg_data;
                end
            end
        end
        i_valid     <= next_valid;
        i_cfg_valid <= next_cfg_valid;
    end

    // ------------------------------------------------------------------
    // Receiver: i_ready follows one of four patterns, picked anew at random on a regular
    // tick. Once, after 300 inputs, it holds off for a long stretch while the
    // sender keeps offering, so the block fills up and has to stall its input.
    // ------------------------------------------------------------------
    int rx_tick        = 0;
    int rx_mode        = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        logic next_ready;
        rx_tick++;
        if (!long_hold_done && inputs_taken >= HOLD_TRIGGER) begin
            hold_left      = HOLD_CYCLES;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else begin
            case (rx_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = 1'($urandom_range(0, 1));
                2:       next_ready = (rx_tick % 5) < 3;
                default: next_ready = $urandom_range(0, 7) != 0;
            endcase
        end
        if (rx_tick % 150 == 0) rx_mode = $urandom_range(0, 3);
        i_ready <= next_ready;
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge it checks an accepted result against the
    // oldest expectation, applies a register write to the predictor, predicts
    // the result of an accepted input, and keeps the stall watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_site_result want;
        bit           out_fire;
        in_fire  = i_rst_n && i_valid && o_ready;
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        out_fire = i_rst_n && o_valid && i_ready;
        if (out_fire) begin
            if (awaited_sites.size() == 0) begin
                $error("result transaction at position %0d with nothing expected", o_position);
                mismatches++;
            end else begin
                want = awaited_sites.pop_front();
                check_field("position", 16'(want.position), 16'(o_position));
                check_field("partner",  16'(want.partner),  16'(o_partner));
                check_field("paired",   16'(want.paired),   16'(o_paired));
                check_field("status",   16'(want.status),   16'(o_status));
                check_field("done_res", 16'(want.done),     16'(o_done_res));
            end
        end
        if (cfg_fire) begin
            case (i_cfg_index)
                CFG_MIN_LOOP: loop_limit = i_cfg_data[MIN_LOOP_W-1:0];
                CFG_ALLOWED:  pair_mask  = i_cfg_data[PAIRS_W-1:0];
                default: ;
            endcase
        end
        if (in_fire) begin
            awaited_sites.push_back(predict_site(i_symbol, i_base, i_last));
            inputs_taken++;
        end
        if (in_fire || cfg_fire || out_fire || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_dot_bracket_pair_parser NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        // Directed part, at the reset settings (min_loop 3, the six usual pairs).
        // A clean hairpin: G at 0 pairs with C at 5, four unpaired positions between.
        queue_item(SYM_OPEN,  BASE_G, 1'b0);
        queue_item(SYM_DOT,   BASE_A, 1'b0);
        queue_item(SYM_DOT,   BASE_C, 1'b0);
        queue_item(SYM_DOT,   BASE_U, 1'b0);
        queue_item(SYM_DOT,   BASE_G, 1'b0);
        queue_item(SYM_CLOSE, BASE_C, 1'b1);
        // A close with nothing open; the open after it is ignored.
        queue_item(SYM_CLOSE, BASE_A, 1'b0);
        queue_item(SYM_OPEN,  BASE_U, 1'b0);
        queue_item(SYM_DOT,   BASE_U, 1'b1);
        // Hairpin loop too short: the pair is only two positions apart.
        queue_item(SYM_OPEN,  BASE_A, 1'b0);
        queue_item(SYM_DOT,   BASE_C, 1'b0);
        queue_item(SYM_CLOSE, BASE_U, 1'b1);
        // Loop long enough, but A-A is not an allowed pair.
        queue_item(SYM_OPEN,  BASE_A, 1'b0);
        queue_item(SYM_DOT,   BASE_G, 1'b0);
        queue_item(SYM_DOT,   BASE_G, 1'b0);
        queue_item(SYM_DOT,   BASE_G, 1'b0);
        queue_item(SYM_DOT,   BASE_G, 1'b0);
        queue_item(SYM_CLOSE, BASE_A, 1'b1);
        // An open left unclosed at the last position.
        queue_item(SYM_OPEN,  BASE_C, 1'b0);
        queue_item(SYM_DOT,   BASE_A, 1'b1);
        // The meaningless symbol acts as a dot; a lone close on a last position.
        queue_item(SYM_SPARE, BASE_U, 1'b1);
        queue_item(SYM_CLOSE, BASE_G, 1'b1);

        queue_random_phase(40);

        // Stack overflow: the stack fills exactly, then the 513th open finds it full.
        for (int i = 0; i <= STACK_DEPTH; i++) queue_item(SYM_OPEN, BASE_C, 1'b0);
        queue_item(SYM_DOT, BASE_G, 1'b1);

        // Loosest settings: no minimum loop and every pair allowed.
        queue_write(CFG_MIN_LOOP, 16'd0);
        queue_write(CFG_ALLOWED,  16'hFFFF);
        queue_item(SYM_OPEN,  BASE_A, 1'b0);
        queue_item(SYM_CLOSE, BASE_A, 1'b1);
        queue_random_phase(40);

        // Strictest loop length with the usual pairs.
        queue_write(CFG_MIN_LOOP, 16'd15);
        queue_write(CFG_ALLOWED,  ALLOWED_RST);
        queue_random_phase(40);

        // No pair allowed at all: every complete pair must fail the nucleotide check.
        queue_write(CFG_ALLOWED,  16'h0000);
        queue_write(CFG_MIN_LOOP, 16'd7);
        queue_random_phase(30);

        // Writes to the undecoded indexes must leave both registers alone.
        queue_write(CFG_RSVD2, 16'($urandom()));
        queue_write(CFG_RSVD3, 16'($urandom()));
        queue_random_phase(20);

        queue_write(CFG_MIN_LOOP, 16'($urandom_range(0, 15)));
        queue_write(CFG_ALLOWED,  16'($urandom()));
        queue_random_phase(40);

        queue_write(CFG_MIN_LOOP, 16'd1);
        queue_write(CFG_ALLOWED,  16'($urandom()));
        queue_random_phase(40);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every transaction has been taken and every result checked.
        while (stim_q.size() != 0 || i_valid || i_cfg_valid || awaited_sites.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_dot_bracket_pair_parser OK");
        end else begin
            $display("tb_dot_bracket_pair_parser NOT OK");
        end
        $finish;
    end

endmodule
